FILE: rtl/core/mlfq_pkg.sv
// Shared types, constants and helper functions of the multilevel feedback queue scheduler.
package mlfq_pkg;

  // Sizes of the scheduler.
  localparam int LEVELS    = 6;
  localparam int PROCESSES = 64;
  localparam int PID_W     = 6;
  localparam int LVL_W     = 3;
  localparam int SLICE_W   = 13;
  localparam int BASE_W    = 8;
  localparam int CNT_W     = 7;

  // Widest value a reload shift can produce before saturation.
  localparam int RELOAD_W = BASE_W + (1 << LVL_W) - 1;

  typedef logic [PID_W-1:0]   pid_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [SLICE_W-1:0] slice_t;
  typedef logic [BASE_W-1:0]  base_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam slice_t SLICE_MAX  = '1;
  localparam base_t  BASE_RESET = 8'd5;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PICK    = 2'd2,
    OP_TICK    = 2'd3
  } opcode_e;

  // One entry of the per-process table.
  typedef struct packed {
    lvl_t   level;
    slice_t slice;
  } proc_entry_t;

  // One result word as held in the output register.
  typedef struct packed {
    logic   pick_valid;
    pid_t   picked_id;
    logic   resched_req;
    slice_t slice_left;
    cnt_t   queued_count;
  } rsp_t;

  // Slice of a level: base shifted left by the level, saturated.
  function automatic slice_t reload_slice(base_t base, lvl_t lvl);
    logic [RELOAD_W-1:0] wide;
    wide = RELOAD_W'(base) << lvl;
    if (wide > RELOAD_W'(SLICE_MAX)) begin
      return SLICE_MAX;
    end
    return wide[SLICE_W-1:0];
  endfunction

  // Levels beyond the lowest one map onto the lowest one.
  function automatic lvl_t clamp_level(lvl_t lvl);
    return (lvl > lvl_t'(LEVELS - 1)) ? lvl_t'(LEVELS - 1) : lvl;
  endfunction

endpackage

FILE: rtl/core/mlfq_if.sv
// Valid/ready channel interfaces for the scheduler's command and result words.
interface mlfq_cmd_if;
  import mlfq_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  pid_t       process_id;

  modport source (output valid, output opcode, output process_id, input ready);
  modport sink   (input valid, input opcode, input process_id, output ready);
endinterface

interface mlfq_rsp_if;
  import mlfq_pkg::*;

  logic   valid;
  logic   ready;
  logic   pick_valid;
  pid_t   picked_id;
  logic   resched_req;
  slice_t slice_left;
  cnt_t   queued_count;

  modport source (output valid, output pick_valid, output picked_id, output resched_req,
                  output slice_left, output queued_count, input ready);
  modport sink   (input valid, input pick_valid, input picked_id, input resched_req,
                  input slice_left, input queued_count, output ready);
endinterface

FILE: rtl/core/mlfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port returns the old contents on a same-cycle write and holds when idle.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mlfq_process_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
//
//   Channel   Direction  Carries
//   cmd_i     in         opcode, process_id
//   rsp_o     out        pick_valid, picked_id, resched_req, slice_left, queued_count
//   cfg       in         base_slice (cfg_we_i, cfg_wdata_i)
//
// One word enters per cycle while the execute stage is free to pass its word on; the
// table reads are registered at the accepting edge together with the word, and
// execution completes into the result register once the output is free.
// Reset clears levels, slices, queue flags and the count at once; no clearing pass.
// A stalled result holds the execute stage, which in turn holds cmd_i.ready low.
module mlfq_process_scheduler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  mlfq_cmd_if.sink              cmd_i,
  mlfq_rsp_if.source            rsp_o
);
  import mlfq_pkg::*;

  // Index of the highest-priority non-empty level.
  function automatic lvl_t first_level(logic [LEVELS-1:0] nonempty);
    lvl_t lvl;
    lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        lvl = lvl_t'(i);
      end
    end
    return lvl;
  endfunction

  // Handshake and pipeline control.
  logic    accept, commit;
  logic    ex_valid_q;
  opcode_e ex_op_q;
  pid_t    ex_id_q, ex_paddr_q;
  logic    rsp_valid_q;
  rsp_t    rsp_q, rsp_d;

  // Scheduler state in flip-flops.
  base_t              base_q;
  pid_t               head_q [LEVELS];
  pid_t               head_d [LEVELS];
  pid_t               head_nx [LEVELS];
  pid_t               tail_q [LEVELS];
  pid_t               tail_d [LEVELS];
  logic [LEVELS-1:0]  nonempty_q, nonempty_d, nonempty_nx;
  logic [PROCESSES-1:0] queued_q, queued_d;
  logic [PROCESSES-1:0] pvalid_q;
  cnt_t               total_q, total_d;

  // Table ports.
  pid_t        acc_paddr;
  proc_entry_t proc_rdata, proc_raw, proc_cur, proc_wdata;
  pid_t        next_rdata, next_cur, next_waddr, next_wdata;
  pid_t        prev_rdata, prev_cur, prev_waddr, prev_wdata;
  lvl_t        lol_rdata, lol_cur, lol_wdata;
  logic        proc_we, next_we, prev_we, lol_we;

  // Bypass of the write made in the same cycle as the read was issued.
  logic        pfwd_en_q, nfwd_en_q, rfwd_en_q, lfwd_en_q;
  pid_t        pfwd_addr_q, nfwd_addr_q, nfwd_data_q, rfwd_addr_q, rfwd_data_q, lfwd_addr_q;
  proc_entry_t pfwd_data_q;
  lvl_t        lfwd_data_q;

  // Execute-stage decode.
  logic   pick_found;
  lvl_t   enq_lvl, deq_lvl;
  slice_t reload;
  logic   at_head, at_tail;

  assign commit        = ex_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign cmd_i.ready   = !ex_valid_q || commit;
  assign accept        = cmd_i.valid && cmd_i.ready;

  // Level state as it stands after this cycle's commit, for the pick address.
  always_comb begin
    if (commit) begin
      nonempty_nx = nonempty_d;
      head_nx     = head_d;
    end else begin
      nonempty_nx = nonempty_q;
      head_nx     = head_q;
    end
    acc_paddr   = (opcode_e'(cmd_i.opcode) == OP_PICK) ? head_nx[first_level(nonempty_nx)]
                                                       : cmd_i.process_id;
  end

  // Table read data with bypass and the reset-value mask.
  always_comb begin
    proc_raw = (pfwd_en_q && pfwd_addr_q == ex_paddr_q) ? pfwd_data_q : proc_rdata;
    proc_cur = pvalid_q[ex_paddr_q] ? proc_raw : '0;
    next_cur = (nfwd_en_q && nfwd_addr_q == ex_id_q) ? nfwd_data_q : next_rdata;
    prev_cur = (rfwd_en_q && rfwd_addr_q == ex_id_q) ? rfwd_data_q : prev_rdata;
    lol_cur  = (lfwd_en_q && lfwd_addr_q == ex_id_q) ? lfwd_data_q : lol_rdata;
  end

  // Execute one word: state updates, table writes and the result word.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    nonempty_d = nonempty_q;
    queued_d   = queued_q;
    total_d    = total_q;
    proc_we    = 1'b0;
    proc_wdata = proc_cur;
    next_we    = 1'b0;
    next_waddr = ex_id_q;
    next_wdata = ex_id_q;
    prev_we    = 1'b0;
    prev_waddr = ex_id_q;
    prev_wdata = ex_id_q;
    lol_we     = 1'b0;
    pick_found = |nonempty_q;
    enq_lvl    = clamp_level(proc_cur.level);
    deq_lvl    = clamp_level(lol_cur);
    lol_wdata  = enq_lvl;
    reload     = reload_slice(base_q, enq_lvl);
    at_head    = (head_q[deq_lvl] == ex_id_q);
    at_tail    = (tail_q[deq_lvl] == ex_id_q);
    rsp_d      = '0;

    case (ex_op_q)
      OP_PICK: begin
        if (pick_found) begin
          proc_we = 1'b1;
          if (proc_cur.level < lvl_t'(LEVELS - 1)) begin
            proc_wdata.level = proc_cur.level + lvl_t'(1);
          end
        end
      end
      OP_ENQUEUE: begin
        if (!queued_q[ex_id_q]) begin
          // Append behind the current tail, or start a new list.
          if (nonempty_q[enq_lvl]) begin
            next_we    = 1'b1;
            next_waddr = tail_q[enq_lvl];
            prev_we    = 1'b1;
            prev_wdata = tail_q[enq_lvl];
          end else begin
            head_d[enq_lvl]     = ex_id_q;
            nonempty_d[enq_lvl] = 1'b1;
          end
          tail_d[enq_lvl]   = ex_id_q;
          lol_we            = 1'b1;
          queued_d[ex_id_q] = 1'b1;
          total_d           = total_q + cnt_t'(1);
          proc_we           = 1'b1;
          if (proc_cur.slice == '0 || proc_cur.slice > reload) begin
            proc_wdata.slice = reload;
          end
        end
      end
      OP_DEQUEUE: begin
        if (queued_q[ex_id_q]) begin
          // Unlink from the list the id was appended to.
          if (at_head && at_tail) begin
            nonempty_d[deq_lvl] = 1'b0;
          end else if (at_head) begin
            head_d[deq_lvl] = next_cur;
          end else if (at_tail) begin
            tail_d[deq_lvl] = prev_cur;
          end else begin
            next_we    = 1'b1;
            next_waddr = prev_cur;
            next_wdata = next_cur;
            prev_we    = 1'b1;
            prev_waddr = next_cur;
            prev_wdata = prev_cur;
          end
          queued_d[ex_id_q] = 1'b0;
          total_d           = total_q - cnt_t'(1);
        end
      end
      OP_TICK: begin
        proc_we = 1'b1;
        if (proc_cur.slice != '0) begin
          proc_wdata.slice = proc_cur.slice - slice_t'(1);
        end
        rsp_d.resched_req = (proc_wdata.slice == '0);
      end
      default: ;
    endcase

    // Result word.
    if (ex_op_q == OP_PICK) begin
      if (pick_found) begin
        rsp_d.pick_valid = 1'b1;
        rsp_d.picked_id  = ex_paddr_q;
        rsp_d.slice_left = proc_cur.slice;
      end
    end else begin
      rsp_d.slice_left = proc_wdata.slice;
    end
    rsp_d.queued_count = total_d;
  end

  // Per-process level and slice.
  mlfq_ram #(.WIDTH($bits(proc_entry_t)), .DEPTH(PROCESSES)) u_proc_ram (
    .clk_i   (clk_i),
    .we_i    (commit && proc_we),
    .waddr_i (ex_paddr_q),
    .wdata_i (proc_wdata),
    .re_i    (accept),
    .raddr_i (acc_paddr),
    .rdata_o (proc_rdata)
  );

  // Forward links of the level lists.
  mlfq_ram #(.WIDTH(PID_W), .DEPTH(PROCESSES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (commit && next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (accept),
    .raddr_i (cmd_i.process_id),
    .rdata_o (next_rdata)
  );

  // Backward links of the level lists.
  mlfq_ram #(.WIDTH(PID_W), .DEPTH(PROCESSES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (commit && prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (accept),
    .raddr_i (cmd_i.process_id),
    .rdata_o (prev_rdata)
  );

  // Level whose list each queued id was appended to.
  mlfq_ram #(.WIDTH(LVL_W), .DEPTH(PROCESSES)) u_lol_ram (
    .clk_i   (clk_i),
    .we_i    (commit && lol_we),
    .waddr_i (ex_id_q),
    .wdata_i (lol_wdata),
    .re_i    (accept),
    .raddr_i (cmd_i.process_id),
    .rdata_o (lol_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      base_q      <= BASE_RESET;
      nonempty_q  <= '0;
      queued_q    <= '0;
      pvalid_q    <= '0;
      total_q     <= '0;
      pfwd_en_q   <= 1'b0;
      nfwd_en_q   <= 1'b0;
      rfwd_en_q   <= 1'b0;
      lfwd_en_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (cmd_i.ready) begin
        ex_valid_q <= cmd_i.valid;
      end
      if (commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (commit) begin
        nonempty_q <= nonempty_d;
        queued_q   <= queued_d;
        total_q    <= total_d;
        if (proc_we) begin
          pvalid_q[ex_paddr_q] <= 1'b1;
        end
      end
      // The bypass stays with the word whose reads were issued at this edge.
      if (accept) begin
        pfwd_en_q <= commit && proc_we;
        nfwd_en_q <= commit && next_we;
        rfwd_en_q <= commit && prev_we;
        lfwd_en_q <= commit && lol_we;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_op_q     <= opcode_e'(cmd_i.opcode);
      ex_id_q     <= cmd_i.process_id;
      ex_paddr_q  <= acc_paddr;
      pfwd_addr_q <= ex_paddr_q;
      pfwd_data_q <= proc_wdata;
      nfwd_addr_q <= next_waddr;
      nfwd_data_q <= next_wdata;
      rfwd_addr_q <= prev_waddr;
      rfwd_data_q <= prev_wdata;
      lfwd_addr_q <= ex_id_q;
      lfwd_data_q <= lol_wdata;
    end
    if (commit) begin
      rsp_q  <= rsp_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.pick_valid   = rsp_q.pick_valid;
  assign rsp_o.picked_id    = rsp_q.picked_id;
  assign rsp_o.resched_req  = rsp_q.resched_req;
  assign rsp_o.slice_left   = rsp_q.slice_left;
  assign rsp_o.queued_count = rsp_q.queued_count;

endmodule

FILE: rtl/core/mlfq_checker.sv
// Port-level checks of the scheduler, bound to its top level.
module mlfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        pick_valid_i,
  input logic [5:0]  picked_id_i,
  input logic        resched_req_i,
  input logic [12:0] slice_left_i,
  input logic [6:0]  queued_count_i
);

  // A word that finds the output free in the cycle after acceptance yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_i) ##1 (!rsp_valid_i || rsp_ready_i) |=> rsp_valid_i)
    else $error("accepted word produced no result");

  // With the output empty nothing can hold the command side back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> cmd_ready_i)
    else $error("command stalled while the output is empty");

  // A successful pick means at least one process is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && pick_valid_i) |-> (queued_count_i != 7'd0))
    else $error("pick reported with an empty queue count");

  // A reschedule request only comes with an exhausted slice and no pick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && resched_req_i) |-> (slice_left_i == 13'd0 && !pick_valid_i))
    else $error("reschedule flagged with slice left");

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(slice_left_i) && $stable(picked_id_i)
       && $stable(queued_count_i)))
    else $error("result word changed while stalled");

endmodule

bind mlfq_process_scheduler mlfq_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .pick_valid_i   (rsp_o.pick_valid),
  .picked_id_i    (rsp_o.picked_id),
  .resched_req_i  (rsp_o.resched_req),
  .slice_left_i   (rsp_o.slice_left),
  .queued_count_i (rsp_o.queued_count)
);
